FILE: design/rifd_pkg.sv
package rifd_pkg;

    // field widths of one transaction
    localparam int FMT_W  = 6;
    localparam int INST_W = 32;
    localparam int ADDR_W = 64;
    localparam int RD_W   = 6;
    localparam int REG_W  = 5;
    localparam int CSR_W  = 12;
    localparam int RM_W   = 3;

    // machine width and the split of the address adder
    localparam int XLEN_DEFAULT = 64;
    localparam int LO_W         = 32;
    localparam int HI_W         = ADDR_W - LO_W;

    // compressed 3-bit register fields address x8..x15
    localparam logic [1:0] CREG_HI = 2'b01;

    // format codes
    localparam logic [FMT_W-1:0] FMT_R          = 6'd0;
    localparam logic [FMT_W-1:0] FMT_I          = 6'd1;
    localparam logic [FMT_W-1:0] FMT_SHIFTI     = 6'd2;
    localparam logic [FMT_W-1:0] FMT_SHIFTIW    = 6'd3;
    localparam logic [FMT_W-1:0] FMT_S          = 6'd4;
    localparam logic [FMT_W-1:0] FMT_B          = 6'd5;
    localparam logic [FMT_W-1:0] FMT_J          = 6'd6;
    localparam logic [FMT_W-1:0] FMT_AUIPC      = 6'd7;
    localparam logic [FMT_W-1:0] FMT_LUI        = 6'd8;
    localparam logic [FMT_W-1:0] FMT_I_F        = 6'd9;
    localparam logic [FMT_W-1:0] FMT_R4_FRM     = 6'd10;
    localparam logic [FMT_W-1:0] FMT_R_FRM      = 6'd11;
    localparam logic [FMT_W-1:0] FMT_R_F        = 6'd12;
    localparam logic [FMT_W-1:0] FMT_CSRR       = 6'd13;
    localparam logic [FMT_W-1:0] FMT_CSRI       = 6'd14;
    localparam logic [FMT_W-1:0] FMT_C_LWSP     = 6'd15;
    localparam logic [FMT_W-1:0] FMT_C_SWSP     = 6'd16;
    localparam logic [FMT_W-1:0] FMT_C_LWSW     = 6'd17;
    localparam logic [FMT_W-1:0] FMT_C_J        = 6'd18;
    localparam logic [FMT_W-1:0] FMT_C_JALR     = 6'd19;
    localparam logic [FMT_W-1:0] FMT_C_B        = 6'd20;
    localparam logic [FMT_W-1:0] FMT_C_LI       = 6'd21;
    localparam logic [FMT_W-1:0] FMT_C_LUI      = 6'd22;
    localparam logic [FMT_W-1:0] FMT_C_ADDI     = 6'd23;
    localparam logic [FMT_W-1:0] FMT_C_ADDI16SP = 6'd24;
    localparam logic [FMT_W-1:0] FMT_C_ADDI4SPN = 6'd25;
    localparam logic [FMT_W-1:0] FMT_C_SLLI     = 6'd26;
    localparam logic [FMT_W-1:0] FMT_C_I        = 6'd27;
    localparam logic [FMT_W-1:0] FMT_C_SHIFTI   = 6'd28;
    localparam logic [FMT_W-1:0] FMT_C_MVADD    = 6'd29;
    localparam logic [FMT_W-1:0] FMT_C_R        = 6'd30;
    localparam logic [FMT_W-1:0] FMT_C_LDSP     = 6'd31;
    localparam logic [FMT_W-1:0] FMT_C_SDSP     = 6'd32;
    localparam logic [FMT_W-1:0] FMT_C_LDSD     = 6'd33;
    localparam logic [FMT_W-1:0] FMT_NONE       = 6'd34;

    // register fields that ride along the pipeline untouched
    typedef struct packed {
        logic [RD_W-1:0]  rd;
        logic [REG_W-1:0] rs1;
        logic [REG_W-1:0] rs2;
        logic [REG_W-1:0] rs3;
        logic [CSR_W-1:0] csr_addr;
        logic [RM_W-1:0]  round_mode;
    } regs_t;

    // what decode hands to the adder stages
    typedef struct packed {
        regs_t             regs;
        logic [ADDR_W-1:0] val;     // immediate or pc offset
        logic              add_pc;  // result is pc plus val
        logic              to_npc;  // result goes to next_pc, else to imm
    } dec_t;

endpackage

FILE: design/rifd_in_if.sv
interface rifd_in_if import rifd_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [FMT_W-1:0]  format;
    logic [INST_W-1:0] inst;
    logic [ADDR_W-1:0] pc;

    modport source (output valid, output format, output inst, output pc, input ready);
    modport sink   (input valid, input format, input inst, input pc, output ready);

endinterface

FILE: design/rifd_out_if.sv
interface rifd_out_if import rifd_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [RD_W-1:0]   rd;
    logic [REG_W-1:0]  rs1;
    logic [REG_W-1:0]  rs2;
    logic [REG_W-1:0]  rs3;
    logic [CSR_W-1:0]  csr_addr;
    logic [ADDR_W-1:0] imm;
    logic [ADDR_W-1:0] next_pc;
    logic [RM_W-1:0]   round_mode;

    modport source (
        output valid, output rd, output rs1, output rs2, output rs3,
        output csr_addr, output imm, output next_pc, output round_mode,
        input ready
    );
    modport sink (
        input valid, input rd, input rs1, input rs2, input rs3,
        input csr_addr, input imm, input next_pc, input round_mode,
        output ready
    );

endinterface

FILE: design/riscv_instruction_field_decoder.sv
// riscv instruction field decoder
//
// fetch channel: one transaction carries an instruction word, its pc and a
// format code picked by an earlier stage. decoded channel: one transaction
// per instruction with the register numbers, csr address, reassembled
// immediate, branch or jump target and rounding-mode field of that format.
// results leave in the same order as the instructions came in.
//
// three register stages, decode, low half of the pc adder and high half of
// the pc adder; a transaction accepted on fetch passes through them in that
// order before it shows valid on decoded. one instruction is accepted every
// cycle while the output is taken; the 64-bit pc add, cut into two 32-bit
// halves, sets the depth of the pipe.
//
// each stage holds a valid bit. a stage loads when it is empty or when the
// stage after it moves on, so bubbles close up and a receiver that stalls
// only holds the stages that are full; fetch ready drops once all three are.
// reset clears the valid bits; no transaction is lost or repeated on a stall.
module riscv_instruction_field_decoder import rifd_pkg::*; #(
    parameter int XLEN = XLEN_DEFAULT
) (
    input logic         clk,
    input logic         rst_n,
    rifd_in_if.sink     fetch,
    rifd_out_if.source  decoded
);

    localparam bit WIDE = (XLEN > 32);
    // results are xlen-bit patterns, zero above
    localparam logic [ADDR_W-1:0] XMASK = {ADDR_W{1'b1}} >> (ADDR_W - XLEN);

    // stage enables, back to front
    logic en1, en2, en3;

    logic              v1_reg, v2_reg, v3_reg;
    dec_t              s1_reg, dec_next;
    logic [ADDR_W-1:0] pc1_reg;

    // stage 2: low half of the sum done
    regs_t             regs2_reg;
    logic [ADDR_W-1:0] val2_reg;
    logic              add_pc2_reg, to_npc2_reg;
    logic [LO_W-1:0]   lo2_reg;
    logic              carry2_reg;
    logic [HI_W-1:0]   pc_hi2_reg;
    logic [LO_W:0]     lo_sum;

    // stage 3: output register
    regs_t             regs3_reg;
    logic [ADDR_W-1:0] imm3_reg, npc3_reg;
    logic [HI_W-1:0]   hi_sum;
    logic [ADDR_W-1:0] res;

    assign en3 = !v3_reg || decoded.ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign fetch.ready = en1;

    // ------------------------------------------------------------------
    // stage 1: field extraction
    // ------------------------------------------------------------------
    logic [INST_W-1:0] w;
    logic [RD_W-1:0]   ird, frd, cr42_rd, cr97_rd;
    logic [REG_W-1:0]  r1, r2, cr42, cr97;
    logic [5:0]        c6;

    assign w       = fetch.inst;
    assign frd     = {1'b0, w[11:7]};
    // integer x0 destination is flagged in the top bit
    assign ird     = (w[11:7] == 5'd0) ? 6'd32 : {1'b0, w[11:7]};
    assign r1      = w[19:15];
    assign r2      = w[24:20];
    assign c6      = {w[12], w[6:2]};
    assign cr97    = {CREG_HI, w[9:7]};
    assign cr42    = {CREG_HI, w[4:2]};
    assign cr97_rd = {1'b0, cr97};
    assign cr42_rd = {1'b0, cr42};

    always_comb
    begin
        dec_next = '0;
        case (fetch.format)
            FMT_R:
            begin
                dec_next.regs.rd  = ird;
                dec_next.regs.rs1 = r1;
                dec_next.regs.rs2 = r2;
            end
            FMT_I:
            begin
                dec_next.regs.rd  = ird;
                dec_next.regs.rs1 = r1;
                dec_next.val      = ADDR_W'($signed(w[31:20]));
            end
            FMT_SHIFTI:
            begin
                dec_next.regs.rd  = ird;
                dec_next.regs.rs1 = r1;
                dec_next.val      = WIDE ? ADDR_W'(w[25:20]) : ADDR_W'(w[24:20]);
            end
            FMT_SHIFTIW:
            begin
                dec_next.regs.rd  = ird;
                dec_next.regs.rs1 = r1;
                dec_next.val      = ADDR_W'(w[24:20]);
            end
            FMT_S:
            begin
                dec_next.regs.rs1 = r1;
                dec_next.regs.rs2 = r2;
                dec_next.val      = ADDR_W'($signed({w[31:25], w[11:7]}));
            end
            FMT_B:
            begin
                dec_next.regs.rs1 = r1;
                dec_next.regs.rs2 = r2;
                dec_next.val      = ADDR_W'($signed({w[31], w[7], w[30:25],
                                                     w[11:8], 1'b0}));
                dec_next.add_pc   = 1'b1;
                dec_next.to_npc   = 1'b1;
            end
            FMT_J:
            begin
                dec_next.regs.rd = ird;
                dec_next.val     = ADDR_W'($signed({w[31], w[19:12], w[20],
                                                    w[30:21], 1'b0}));
            end
            FMT_AUIPC:
            begin
                dec_next.regs.rd = ird;
                dec_next.val     = ADDR_W'($signed({w[31:12], 12'd0}));
                dec_next.add_pc  = 1'b1;
            end
            FMT_LUI:
            begin
                dec_next.regs.rd = ird;
                dec_next.val     = ADDR_W'($signed({w[31:12], 12'd0}));
            end
            FMT_I_F:
            begin
                dec_next.regs.rd  = frd;
                dec_next.regs.rs1 = r1;
                dec_next.val      = ADDR_W'($signed(w[31:20]));
            end
            FMT_R4_FRM:
            begin
                dec_next.regs.rd         = frd;
                dec_next.regs.rs1        = r1;
                dec_next.regs.rs2        = r2;
                dec_next.regs.rs3        = w[31:27];
                dec_next.regs.round_mode = w[14:12];
            end
            FMT_R_FRM:
            begin
                dec_next.regs.rd         = frd;
                dec_next.regs.rs1        = r1;
                dec_next.regs.rs2        = r2;
                dec_next.regs.round_mode = w[14:12];
            end
            FMT_R_F:
            begin
                dec_next.regs.rd  = frd;
                dec_next.regs.rs1 = r1;
                dec_next.regs.rs2 = r2;
            end
            FMT_CSRR:
            begin
                dec_next.regs.rd       = ird;
                dec_next.regs.rs1      = r1;
                dec_next.regs.csr_addr = w[31:20];
            end
            FMT_CSRI:
            begin
                dec_next.regs.rd       = ird;
                dec_next.regs.csr_addr = w[31:20];
                dec_next.val           = ADDR_W'(r1);
            end
            FMT_C_LWSP:
            begin
                dec_next.regs.rd = ird;
                dec_next.val     = ADDR_W'({w[3:2], w[12], w[6:4], 2'b00});
            end
            FMT_C_SWSP:
            begin
                dec_next.regs.rs2 = w[6:2];
                dec_next.val      = ADDR_W'({w[8:7], w[12:9], 2'b00});
            end
            FMT_C_LWSW:
            begin
                dec_next.regs.rd  = cr42_rd;
                dec_next.regs.rs1 = cr97;
                dec_next.regs.rs2 = cr42;
                dec_next.val      = ADDR_W'({w[5], w[12:10], w[6], 2'b00});
            end
            FMT_C_J:
            begin
                // the word's rd slot is reported as rs1 here too
                dec_next.regs.rs1 = w[11:7];
                dec_next.val      = ADDR_W'($signed({w[12], w[8], w[10:9], w[6],
                                                     w[7], w[2], w[11], w[5:3],
                                                     1'b0}));
                dec_next.add_pc   = 1'b1;
                dec_next.to_npc   = 1'b1;
            end
            FMT_C_JALR:
            begin
                // link address past a compressed instruction
                dec_next.regs.rs1 = w[11:7];
                dec_next.val      = ADDR_W'(2);
                dec_next.add_pc   = 1'b1;
                dec_next.to_npc   = 1'b1;
            end
            FMT_C_B:
            begin
                dec_next.regs.rs1 = cr97;
                dec_next.val      = ADDR_W'($signed({w[12], w[6:5], w[2],
                                                     w[11:10], w[4:3], 1'b0}));
                dec_next.add_pc   = 1'b1;
                dec_next.to_npc   = 1'b1;
            end
            FMT_C_LI, FMT_C_ADDI:
            begin
                dec_next.regs.rd = ird;
                dec_next.val     = ADDR_W'($signed(c6));
            end
            FMT_C_LUI:
            begin
                dec_next.regs.rd = ird;
                dec_next.val     = ADDR_W'($signed({c6, 12'd0}));
            end
            FMT_C_ADDI16SP:
            begin
                dec_next.val = ADDR_W'($signed({w[12], w[4:3], w[5], w[2],
                                                w[6], 4'd0}));
            end
            FMT_C_ADDI4SPN:
            begin
                dec_next.regs.rd = cr42_rd;
                dec_next.val     = ADDR_W'({w[10:7], w[12:11], w[5], w[6], 2'b00});
            end
            FMT_C_SLLI:
            begin
                dec_next.regs.rd = ird;
                dec_next.val     = ADDR_W'(c6);
            end
            FMT_C_I:
            begin
                dec_next.regs.rd = cr97_rd;
                dec_next.val     = ADDR_W'($signed(c6));
            end
            FMT_C_SHIFTI:
            begin
                dec_next.regs.rd = cr97_rd;
                dec_next.val     = WIDE ? ADDR_W'(c6) : ADDR_W'(w[6:2]);
            end
            FMT_C_MVADD:
            begin
                dec_next.regs.rd  = ird;
                dec_next.regs.rs2 = w[6:2];
            end
            FMT_C_R:
            begin
                dec_next.regs.rd  = cr97_rd;
                dec_next.regs.rs2 = cr42;
            end
            // doubleword loads and stores exist only on a 64-bit machine
            FMT_C_LDSP:
            begin
                if (WIDE)
                begin
                    dec_next.regs.rd = ird;
                    dec_next.val     = ADDR_W'({w[4:2], w[12], w[6:5], 3'd0});
                end
            end
            FMT_C_SDSP:
            begin
                if (WIDE)
                begin
                    dec_next.regs.rs2 = w[6:2];
                    dec_next.val      = ADDR_W'({w[9:7], w[12:10], 3'd0});
                end
            end
            FMT_C_LDSD:
            begin
                if (WIDE)
                begin
                    dec_next.regs.rd  = cr42_rd;
                    dec_next.regs.rs1 = cr97;
                    dec_next.regs.rs2 = cr42;
                    dec_next.val      = ADDR_W'({w[6:5], w[12:10], 3'd0});
                end
            end
            // the none format and unassigned codes leave every field zero
            default:
            begin
                dec_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= fetch.valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && fetch.valid)
        begin
            s1_reg  <= dec_next;
            pc1_reg <= fetch.pc;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: low half of pc plus offset
    // ------------------------------------------------------------------
    assign lo_sum = {1'b0, pc1_reg[LO_W-1:0]} + {1'b0, s1_reg.val[LO_W-1:0]};

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            regs2_reg   <= s1_reg.regs;
            val2_reg    <= s1_reg.val;
            add_pc2_reg <= s1_reg.add_pc;
            to_npc2_reg <= s1_reg.to_npc;
            lo2_reg     <= lo_sum[LO_W-1:0];
            carry2_reg  <= lo_sum[LO_W];
            pc_hi2_reg  <= pc1_reg[ADDR_W-1:LO_W];
        end
    end

    // ------------------------------------------------------------------
    // stage 3: high half, select and route to imm or next_pc
    // ------------------------------------------------------------------
    assign hi_sum = pc_hi2_reg + val2_reg[ADDR_W-1:LO_W] + HI_W'(carry2_reg);
    assign res    = (add_pc2_reg ? {hi_sum, lo2_reg} : val2_reg) & XMASK;

    always_ff @(posedge clk)
    begin
        if (en3 && v2_reg)
        begin
            regs3_reg <= regs2_reg;
            imm3_reg  <= to_npc2_reg ? '0 : res;
            npc3_reg  <= to_npc2_reg ? res : '0;
        end
    end

    assign decoded.valid      = v3_reg;
    assign decoded.rd         = regs3_reg.rd;
    assign decoded.rs1        = regs3_reg.rs1;
    assign decoded.rs2        = regs3_reg.rs2;
    assign decoded.rs3        = regs3_reg.rs3;
    assign decoded.csr_addr   = regs3_reg.csr_addr;
    assign decoded.round_mode = regs3_reg.round_mode;
    assign decoded.imm        = imm3_reg;
    assign decoded.next_pc    = npc3_reg;

`ifndef SYNTHESIS
    // fetch is only held off when every stage is occupied
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !fetch.ready |-> (v1_reg && v2_reg && v3_reg))
        else $error("fetch stalled with a free pipeline stage");

    // an accepted transaction always lands in stage 1
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (fetch.valid && fetch.ready) |=> v1_reg)
        else $error("accepted transaction not captured");

    // x0 marking only ever sits on a zero register number
    a_x0_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (decoded.valid && decoded.rd[RD_W-1]) |-> (decoded.rd[RD_W-2:0] == '0))
        else $error("rd x0 flag with nonzero register");

    // a format yields an immediate or a target, never both
    a_imm_npc_excl: assert property (@(posedge clk) disable iff (!rst_n)
        decoded.valid |-> ((decoded.imm == '0) || (decoded.next_pc == '0)))
        else $error("imm and next_pc both set");

    // rounding mode comes only with float formats, which carry no csr
    a_rm_no_csr: assert property (@(posedge clk) disable iff (!rst_n)
        (decoded.valid && (decoded.round_mode != '0)) |-> (decoded.csr_addr == '0))
        else $error("rounding mode alongside csr address");
`endif

endmodule

FILE: dv/rifd_field_checker.sv
`timescale 1ns / 1ps

module rifd_field_checker import rifd_pkg::*; #(
    parameter int XLEN = XLEN_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    rifd_in_if   fetch,
    rifd_out_if  decoded,
    output int   mismatches,
    output int   outstanding,
    output int   checked
);

    localparam int                MAX_REPORTS = 10;
    localparam logic [RD_W-1:0]   X0_MARK     = 6'd32;
    localparam logic [ADDR_W-1:0] XLEN_MASK   = {ADDR_W{1'b1}} >> (ADDR_W - XLEN);

    typedef struct packed {
        logic [RD_W-1:0]   rd;
        logic [REG_W-1:0]  rs1;
        logic [REG_W-1:0]  rs2;
        logic [REG_W-1:0]  rs3;
        logic [CSR_W-1:0]  csr_addr;
        logic [ADDR_W-1:0] imm;
        logic [ADDR_W-1:0] next_pc;
        logic [RM_W-1:0]   round_mode;
    } decode_fields_t;

    decode_fields_t pending_decodes[$];

    function automatic decode_fields_t decode_fields(
        input logic [FMT_W-1:0]  fmt,
        input logic [INST_W-1:0] w,
        input logic [ADDR_W-1:0] pc
    );
        decode_fields_t  f;
        logic [RD_W-1:0]  int_rd;
        logic [REG_W-1:0] c_hi;     // compressed register in bits 9..7
        logic [REG_W-1:0] c_lo;     // compressed register in bits 4..2
        logic [5:0]       c_imm6;
        logic             wide;
        f      = '0;
        int_rd = (w[11:7] == '0) ? X0_MARK : {1'b0, w[11:7]};
        c_hi   = {CREG_HI, w[9:7]};
        c_lo   = {CREG_HI, w[4:2]};
        c_imm6 = {w[12], w[6:2]};
        wide   = (XLEN > 32);
        case (fmt)
            FMT_R:
            begin
                f.rd = int_rd; f.rs1 = w[19:15]; f.rs2 = w[24:20];
            end
            FMT_I:
            begin
                f.rd = int_rd; f.rs1 = w[19:15]; f.imm = {{52{w[31]}}, w[31:20]};
            end
            FMT_SHIFTI:
            begin
                f.rd = int_rd; f.rs1 = w[19:15];
                f.imm = wide ? {58'b0, w[25:20]} : {59'b0, w[24:20]};
            end
            FMT_SHIFTIW:
            begin
                f.rd = int_rd; f.rs1 = w[19:15]; f.imm = {59'b0, w[24:20]};
            end
            FMT_S:
            begin
                f.rs1 = w[19:15]; f.rs2 = w[24:20];
                f.imm = {{52{w[31]}}, w[31:25], w[11:7]};
            end
            FMT_B:
            begin
                f.rs1 = w[19:15]; f.rs2 = w[24:20];
                f.next_pc = pc + {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            end
            FMT_J:
            begin
                f.rd = int_rd;
                f.imm = {{43{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            end
            FMT_AUIPC:
            begin
                f.rd = int_rd; f.imm = pc + {{32{w[31]}}, w[31:12], 12'b0};
            end
            FMT_LUI:
            begin
                f.rd = int_rd; f.imm = {{32{w[31]}}, w[31:12], 12'b0};
            end
            FMT_I_F:
            begin
                f.rd = {1'b0, w[11:7]}; f.rs1 = w[19:15];
                f.imm = {{52{w[31]}}, w[31:20]};
            end
            FMT_R4_FRM:
            begin
                f.rd = {1'b0, w[11:7]}; f.rs1 = w[19:15]; f.rs2 = w[24:20];
                f.rs3 = w[31:27]; f.round_mode = w[14:12];
            end
            FMT_R_FRM:
            begin
                f.rd = {1'b0, w[11:7]}; f.rs1 = w[19:15]; f.rs2 = w[24:20];
                f.round_mode = w[14:12];
            end
            FMT_R_F:
            begin
                f.rd = {1'b0, w[11:7]}; f.rs1 = w[19:15]; f.rs2 = w[24:20];
            end
            FMT_CSRR:
            begin
                f.rd = int_rd; f.rs1 = w[19:15]; f.csr_addr = w[31:20];
            end
            FMT_CSRI:
            begin
                f.rd = int_rd; f.csr_addr = w[31:20]; f.imm = {59'b0, w[19:15]};
            end
            FMT_C_LWSP:
            begin
                f.rd = int_rd; f.imm = {56'b0, w[3:2], w[12], w[6:4], 2'b0};
            end
            FMT_C_SWSP:
            begin
                f.rs2 = w[6:2]; f.imm = {56'b0, w[8:7], w[12:9], 2'b0};
            end
            FMT_C_LWSW:
            begin
                f.rd = {1'b0, c_lo}; f.rs1 = c_hi; f.rs2 = c_lo;
                f.imm = {57'b0, w[5], w[12:10], w[6], 2'b0};
            end
            FMT_C_J:
            begin
                f.rs1 = w[11:7];
                f.next_pc = pc + {{52{w[12]}}, w[12], w[8], w[10:9], w[6], w[7],
                                  w[2], w[11], w[5:3], 1'b0};
            end
            FMT_C_JALR:
            begin
                f.rs1 = w[11:7]; f.next_pc = pc + 64'd2;
            end
            FMT_C_B:
            begin
                f.rs1 = c_hi;
                f.next_pc = pc + {{55{w[12]}}, w[12], w[6:5], w[2], w[11:10], w[4:3], 1'b0};
            end
            FMT_C_LI, FMT_C_ADDI:
            begin
                f.rd = int_rd; f.imm = {{58{w[12]}}, c_imm6};
            end
            FMT_C_LUI:
            begin
                f.rd = int_rd; f.imm = {{46{w[12]}}, w[12], w[6:2], 12'b0};
            end
            FMT_C_ADDI16SP:
                f.imm = {{54{w[12]}}, w[12], w[4:3], w[5], w[2], w[6], 4'b0};
            FMT_C_ADDI4SPN:
            begin
                f.rd = {1'b0, c_lo};
                f.imm = {54'b0, w[10:7], w[12:11], w[5], w[6], 2'b0};
            end
            FMT_C_SLLI:
            begin
                f.rd = int_rd; f.imm = {58'b0, c_imm6};
            end
            FMT_C_I:
            begin
                f.rd = {1'b0, c_hi}; f.imm = {{58{w[12]}}, c_imm6};
            end
            FMT_C_SHIFTI:
            begin
                f.rd = {1'b0, c_hi};
                f.imm = wide ? {58'b0, c_imm6} : {59'b0, w[6:2]};
            end
            FMT_C_MVADD:
            begin
                f.rd = int_rd; f.rs2 = w[6:2];
            end
            FMT_C_R:
            begin
                f.rd = {1'b0, c_hi}; f.rs2 = c_lo;
            end
            FMT_C_LDSP:
                if (wide)
                begin
                    f.rd = int_rd; f.imm = {55'b0, w[4:2], w[12], w[6:5], 3'b0};
                end
            FMT_C_SDSP:
                if (wide)
                begin
                    f.rs2 = w[6:2]; f.imm = {55'b0, w[9:7], w[12:10], 3'b0};
                end
            FMT_C_LDSD:
                if (wide)
                begin
                    f.rd = {1'b0, c_lo}; f.rs1 = c_hi; f.rs2 = c_lo;
                    f.imm = {56'b0, w[6:5], w[12:10], 3'b0};
                end
            default:
                f = '0;
        endcase
        f.imm     = f.imm & XLEN_MASK;
        f.next_pc = f.next_pc & XLEN_MASK;
        return f;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch on %s: expected %h, got %h", name, want, got);
        end
    endtask

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
        checked     = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin : watch
        decode_fields_t want;
        if (!rst_n)
        begin
            pending_decodes.delete();
            outstanding = 0;
        end
        else
        begin
            if (fetch.valid && fetch.ready)
                pending_decodes.push_back(decode_fields(fetch.format, fetch.inst, fetch.pc));
            if (decoded.valid && decoded.ready)
            begin
                if (pending_decodes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected decoded transaction: rd %h imm %h",
                                 decoded.rd, decoded.imm);
                end
                else
                begin
                    want = pending_decodes.pop_front();
                    checked++;
                    compare_field("rd", ADDR_W'(want.rd), ADDR_W'(decoded.rd));
                    compare_field("rs1", ADDR_W'(want.rs1), ADDR_W'(decoded.rs1));
                    compare_field("rs2", ADDR_W'(want.rs2), ADDR_W'(decoded.rs2));
                    compare_field("rs3", ADDR_W'(want.rs3), ADDR_W'(decoded.rs3));
                    compare_field("csr_addr", ADDR_W'(want.csr_addr),
                                  ADDR_W'(decoded.csr_addr));
                    compare_field("imm", want.imm, decoded.imm);
                    compare_field("next_pc", want.next_pc, decoded.next_pc);
                    compare_field("round_mode", ADDR_W'(want.round_mode),
                                  ADDR_W'(decoded.round_mode));
                end
            end
            outstanding = pending_decodes.size();
        end
    end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;

    import rifd_pkg::*;

    localparam int XLEN         = XLEN_DEFAULT;
    localparam int RANDOM_ITEMS = 400;
    localparam int LONG_HOLD    = 40;     // cycles the output side refuses transactions
    localparam int TAIL_CYCLES  = 10;     // well past the three-stage latency

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // handshakes between the fetch driver and the decoded-side receiver
    bit long_hold_req = 1'b0;
    bit no_idle       = 1'b0;

    int mismatches;
    int outstanding;
    int checked;

    rifd_in_if  fetch_bus ();
    rifd_out_if decoded_bus ();

    riscv_instruction_field_decoder #(.XLEN(XLEN)) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .fetch   (fetch_bus),
        .decoded (decoded_bus)
    );

    // watches both channels, predicts every decoded transaction and compares
    rifd_field_checker #(.XLEN(XLEN)) field_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .fetch       (fetch_bus),
        .decoded     (decoded_bus),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked)
    );

    always #10 clk = ~clk;

    // hard stop well beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // pc values, half bunched at both ends of the address space so the adders wrap
    function automatic logic [ADDR_W-1:0] random_pc();
        logic [ADDR_W-1:0] addr;
        case ($urandom_range(0, 3))
            0:       addr = ADDR_W'($urandom_range(0, 255));
            1:       addr = {ADDR_W{1'b1}} - ADDR_W'($urandom_range(0, 255));
            default: addr = {$urandom, $urandom};
        endcase
        return addr;
    endfunction

    // one fetch transaction: optional idle gap, then hold until accepted
    task automatic offer_instruction(input logic [FMT_W-1:0] fmt,
                                     input logic [INST_W-1:0] w,
                                     input logic [ADDR_W-1:0] addr);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            fetch_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        fetch_bus.valid  <= 1'b1;
        fetch_bus.format <= fmt;
        fetch_bus.inst   <= w;
        fetch_bus.pc     <= addr;
        do
            @(posedge clk);
        while (!fetch_bus.ready);
        @(negedge clk);
    endtask

    // stop offering and wait until every decoded transaction has come back
    task automatic drain_pipeline();
        fetch_bus.valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
    endtask

    // decoded side: random stall per transaction, plus one long hold-off
    // requested by the fetch driver so the pipe fills and fetch ready drops
    initial
    begin : result_sink
        int gap;
        decoded_bus.ready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                decoded_bus.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold_req = 1'b0;
            end
            gap = no_idle ? 0 : $urandom_range(0, 3);
            if (gap > 0)
            begin
                decoded_bus.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            decoded_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(decoded_bus.valid && decoded_bus.ready));
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        logic [FMT_W-1:0]  fmt;
        logic [INST_W-1:0] w;
        fetch_bus.valid  = 1'b0;
        fetch_bus.format = FMT_R;
        fetch_bus.inst   = '0;
        fetch_bus.pc     = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: every format once, alternating an all-zero word at the top
        // of the address space (x0 marking, wrapping targets) with an all-ones
        // word at pc zero (negative offsets, largest register numbers)
        for (int f = FMT_R; f <= FMT_NONE; f++)
        begin
            if (f % 2 == 0)
                offer_instruction(FMT_W'(f), '0, '1);
            else
                offer_instruction(FMT_W'(f), '1, '0);
        end
        // unknown format codes decode to all zero
        offer_instruction(FMT_W'(FMT_NONE + 1), '1, '1);
        offer_instruction({FMT_W{1'b1}}, '1, '0);

        // sender pause: let the pipe empty completely
        drain_pipeline();

        // random part: mostly legal formats, some unknown codes, a stretch with
        // no idling on either side, a long output stall and a mid-run drain
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 120)
                long_hold_req = 1'b1;
            if (n == 200)
                drain_pipeline();
            no_idle = (n >= 250 && n < 320);
            if ($urandom_range(0, 9) == 0)
                fmt = FMT_W'($urandom_range(FMT_NONE + 1, {FMT_W{1'b1}}));
            else
                fmt = FMT_W'($urandom_range(FMT_R, FMT_NONE));
            w = $urandom;
            if ($urandom_range(0, 7) == 0)
                w[11:7] = '0;
            offer_instruction(fmt, w, random_pc());
        end

        drain_pipeline();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("run covered %0d decoded instructions over all %0d formats and unknown codes",
                 checked, FMT_NONE + 1);
        $display("with idle gaps on both sides, a %0d-cycle output stall and full drains",
                 LONG_HOLD);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
